// ===== rtl/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg: shared types and codes for the sorted value list
// Field widths, request and status codes, and the command bundle that
// goes to every cell of the chain.
// ----------------------------------------------------------------------------
package svl_pkg;

    // Default number of cells
    localparam int CAPACITY_DEF = 16;

    // Payload widths
    localparam int VALUE_W = 16;
    localparam int REQ_W   = 2;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Command broadcast to all cells at once
    typedef struct packed {
        logic               ins;    // insert value (list not full)
        logic               rem;    // shift left, dropping cell 0
        logic [VALUE_W-1:0] value;  // value being inserted
    } cell_cmd_t;

endpackage

// ===== rtl/svl_cell.sv =====
// ----------------------------------------------------------------------------
// svl_cell: one storage cell of the sorted list
// Holds one value, compares it with the broadcast insert value and either
// keeps it, takes the new value, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module svl_cell
    import svl_pkg::*;
(
    input  logic               clk,
    input  cell_cmd_t          cmd,
    input  logic               occ,        // cell holds a live value
    input  logic               left_ge,    // left neighbor moves right on insert
    input  logic [VALUE_W-1:0] left_val,
    input  logic [VALUE_W-1:0] right_val,
    output logic               ge,         // insert lands here or to the left
    output logic [VALUE_W-1:0] val,
    output logic [VALUE_W-1:0] val_next
);

    logic [VALUE_W-1:0] val_reg;

    // Free cells count as "greater", so the first free cell takes the value
    assign ge  = !occ || (val_reg >= cmd.value);
    assign val = val_reg;

    // Next value: shift right on insert, shift left on remove
    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins)
        begin
            if (left_ge)
                val_next = left_val;
            else if (ge)
                val_next = cmd.value;
        end
        else if (cmd.rem)
        begin
            val_next = right_val;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/sorted_value_list.sv =====
// ----------------------------------------------------------------------------
// sorted_value_list: bounded ascending list acting as a priority queue
// The result of an accepted request is in the output register in the cycle after its transfer.
// Throughput: 1 request per cycle while results are taken; all cells compare and shift in parallel.
// Reset clears the entry count and the output valid; cell contents stay
// undefined until written and are never read past the count.
// ----------------------------------------------------------------------------
module sorted_value_list
    import svl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ST_W-1:0]    status,
    output logic [VALUE_W-1:0] removed_value,
    output logic [VALUE_W-1:0] head_value,
    output logic [COUNT_W-1:0] entry_count,
    output logic               list_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic               accept;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               full, none;
    cell_cmd_t          cmd;
    logic [ST_W-1:0]    st;
    logic [VALUE_W-1:0] removed;
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] cell_ge;
    logic [VALUE_W-1:0] cell_val  [CAPACITY];
    logic [VALUE_W-1:0] cell_next [CAPACITY];

    logic               out_valid_reg;
    logic [ST_W-1:0]    status_reg;
    logic [VALUE_W-1:0] removed_reg;
    logic [VALUE_W-1:0] head_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic               empty_reg;

    // Output register frees up when its result is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full = (count_reg == CNT_W'(CAPACITY));
    assign none = (count_reg == '0);

    // Request decode
    always_comb
    begin
        cmd.ins    = 1'b0;
        cmd.rem    = 1'b0;
        cmd.value  = value;
        st         = ST_DONE;
        removed    = '0;
        count_next = count_reg;
        if (accept)
        begin
            unique case (req_type)
                REQ_INSERT:
                begin
                    if (full)
                        st = ST_FULL;
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    if (none)
                        st = ST_EMPTY;
                    else
                    begin
                        cmd.rem    = 1'b1;
                        removed    = cell_val[0];
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    st = ST_DONE;
                end
            endcase
        end
    end

    // Occupancy from the count: cell i is live when i < count
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            occ[i] = (CNT_W'(i) < count_reg);
    end

    // Chain of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic               l_ge;
        logic [VALUE_W-1:0] l_val;
        logic [VALUE_W-1:0] r_val;

        if (g == 0)
        begin : g_first
            assign l_ge  = 1'b0;
            assign l_val = '0;
        end
        else
        begin : g_mid
            assign l_ge  = cell_ge[g-1];
            assign l_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign r_val = cell_val[g];
        end
        else
        begin : g_inner
            assign r_val = cell_val[g+1];
        end

        svl_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occ       (occ[g]),
            .left_ge   (l_ge),
            .left_val  (l_val),
            .right_val (r_val),
            .ge        (cell_ge[g]),
            .val       (cell_val[g]),
            .val_next  (cell_next[g])
        );
    end

    // Count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= st;
            removed_reg   <= removed;
            head_reg      <= (count_next != '0) ? cell_next[0] : '0;
            count_out_reg <= COUNT_W'(count_next);
            empty_reg     <= (count_next == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign head_value    = head_reg;
    assign entry_count   = count_out_reg;
    assign list_empty    = empty_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (empty_reg == (count_reg == '0)))
        else $error("empty flag disagrees with count");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_val[0] <= cell_val[1]))
        else $error("first two cells out of order");

endmodule
